// File: hw/rtl/pts_pkg.sv
// Package for the priority task scheduler: action, status and state codes,
// request and result item types. No dependencies.
package pts_pkg;

    typedef enum logic [2:0] {
        ACT_RESUME  = 3'd0,
        ACT_SUSPEND = 3'd1,
        ACT_SETPRIO = 3'd2,
        ACT_WAIT    = 3'd3,
        ACT_NOTIFY  = 3'd4,
        ACT_SWITCH  = 3'd5
    } action_t;

    localparam logic [1:0] TSTAT_READY     = 2'd0;
    localparam logic [1:0] TSTAT_BLOCKED   = 2'd1;
    localparam logic [1:0] TSTAT_SUSPENDED = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_STATE = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 4;
    localparam int PRIOF_W  = 8;
    localparam int EVENTF_W = 32;
    localparam int WOKEN_W  = 5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  task_index;
        logic                use_current;
        logic [PRIOF_W-1:0]  priority_req;
        logic [EVENTF_W-1:0] event_mask;
    } sched_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  running_task;
        logic                reschedule;
        logic [WOKEN_W-1:0]  woken_count;
        logic [EVENTF_W-1:0] delivered_events;
        logic [1:0]          status;
    } sched_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RM_SCAN,
        S_INS_SCAN,
        S_INS_SHIFT,
        S_WAIT_SHIFT,
        S_NOT_SCAN,
        S_POP_SHIFT,
        S_RESULT,
        S_OUT
    } state_t;

endpackage

// File: hw/rtl/pts_if.sv
// Valid/ready channel interface used for request and result items.
// Depends on nothing; payload type set by parameter.
interface pts_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/priority_task_scheduler.sv
// Priority task scheduler: ready queue by priority, wait queue newest first.
// Depends on pts_pkg and pts_if.
// Sequence: an accepted item goes from S_DECODE through any queue scan or shift states
// that its action needs to S_RESULT, and the result is valid in S_OUT.
// Throughput: one item at a time, set by the single sequencer that walks the queue
// registers one entry per cycle; ready returns the cycle after the result is taken.
// Reset (asynchronous, rst_n low): task 0 ready and running, queues empty.
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_TASKS  = 16,
    parameter int EVENT_BITS = 32,
    parameter int PRIO_BITS  = 8
) (
    input  logic clk,
    input  logic rst_n,
    pts_if.sink   req,
    pts_if.source rsp
);
    localparam int TW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);

    state_t state_reg, state_next;

    logic [1:0]            tstat_reg  [NUM_TASKS];
    logic [PRIO_BITS-1:0]  tprio_reg  [NUM_TASKS];
    logic [EVENT_BITS-1:0] tev_reg    [NUM_TASKS];
    logic [TW-1:0]         rord_reg   [NUM_TASKS];
    logic [TW-1:0]         word_reg   [NUM_TASKS];
    logic [CW-1:0]         rcnt_reg, wcnt_reg;
    logic [TW-1:0]         cur_reg;

    logic [ACTION_W-1:0]   act_reg;
    logic [TW-1:0]         tgt_reg;
    logic                  tgt_bad_reg;
    logic [PRIO_BITS-1:0]  prio_reg;
    logic [EVENT_BITS-1:0] mask_reg;
    logic [CW-1:0]         i_reg, j_reg, pos_reg, ni_reg;
    logic                  do_ins_reg;
    logic [TW-1:0]         ins_reg;
    logic [1:0]            stat_reg;
    logic [WOKEN_W-1:0]    woken_reg;
    logic [EVENT_BITS-1:0] deliv_reg;
    logic                  swok_reg;
    logic                  resched_reg;

    logic [INDEX_W-1:0] idx_in;
    logic [TW-1:0]      t_in;
    logic               bad_in;
    logic               resched;

    assign idx_in = req.data.task_index;
    assign t_in   = req.data.use_current ? cur_reg : TW'(idx_in);
    assign bad_in = !req.data.use_current && ({28'd0, idx_in} >= NUM_TASKS);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);

    logic [TW-1:0] ri, wi;
    assign ri = rord_reg[i_reg[TW-1:0]];
    assign wi = word_reg[ni_reg[TW-1:0]];

    assign resched = (tstat_reg[cur_reg] != TSTAT_READY) ||
                     (rcnt_reg != '0 && tprio_reg[rord_reg[0]] < tprio_reg[cur_reg]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (req.valid) state_next = S_DECODE;
            S_DECODE:     state_next = S_RESULT;
            S_RM_SCAN:    if (i_reg >= rcnt_reg)
                              state_next = do_ins_reg ? S_INS_SCAN : S_RESULT;
            S_INS_SCAN:   if (i_reg >= rcnt_reg ||
                              tprio_reg[ri] > tprio_reg[ins_reg])
                              state_next = S_INS_SHIFT;
            S_INS_SHIFT:  if (i_reg <= pos_reg)
                          begin
                              if (act_reg == ACT_SWITCH)
                                  state_next = S_POP_SHIFT;
                              else if (act_reg == ACT_NOTIFY)
                                  state_next = S_NOT_SCAN;
                              else
                                  state_next = S_RESULT;
                          end
            S_WAIT_SHIFT: if (i_reg == '0) state_next = S_RESULT;
            S_NOT_SCAN:   if (ni_reg >= wcnt_reg)
                              state_next = S_RESULT;
                          else if ((tev_reg[wi] & mask_reg) != '0 && wi != cur_reg &&
                                   rcnt_reg < CW'(NUM_TASKS))
                              state_next = S_INS_SCAN;
            S_POP_SHIFT:  if (i_reg >= rcnt_reg) state_next = S_RESULT;
            S_RESULT:     state_next = S_OUT;
            S_OUT:        if (rsp.ready) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
        if (state_reg == S_DECODE)
        begin
            case (act_reg)
                ACT_RESUME:
                    if (!tgt_bad_reg && tstat_reg[tgt_reg] == TSTAT_SUSPENDED &&
                        tgt_reg != cur_reg && rcnt_reg < CW'(NUM_TASKS))
                        state_next = S_INS_SCAN;
                ACT_SUSPEND:
                    if (!tgt_bad_reg && tstat_reg[tgt_reg] == TSTAT_READY &&
                        tgt_reg != cur_reg)
                        state_next = S_RM_SCAN;
                ACT_SETPRIO:
                    if (!tgt_bad_reg && tgt_reg != cur_reg &&
                        tstat_reg[tgt_reg] == TSTAT_READY)
                        state_next = S_RM_SCAN;
                ACT_WAIT:
                    if (mask_reg != '0 && tstat_reg[cur_reg] == TSTAT_READY &&
                        wcnt_reg < CW'(NUM_TASKS))
                        state_next = S_WAIT_SHIFT;
                ACT_NOTIFY:
                    if (mask_reg != '0) state_next = S_NOT_SCAN;
                ACT_SWITCH:
                    if (tstat_reg[cur_reg] == TSTAT_READY && rcnt_reg < CW'(NUM_TASKS))
                        state_next = S_INS_SCAN;
                    else if (rcnt_reg != '0)
                        state_next = S_POP_SHIFT;
                default: state_next = S_RESULT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int k = 0; k < NUM_TASKS; k++)
            begin
                tstat_reg[k] <= (k == 0) ? TSTAT_READY : TSTAT_SUSPENDED;
                tprio_reg[k] <= '0;
                tev_reg[k]   <= '0;
            end
            rcnt_reg    <= '0;
            wcnt_reg    <= '0;
            cur_reg     <= '0;
            resched_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    if (req.valid)
                    begin
                        act_reg     <= req.data.action;
                        tgt_reg     <= t_in;
                        tgt_bad_reg <= bad_in;
                        prio_reg    <= req.data.priority_req[PRIO_BITS-1:0];
                        mask_reg    <= req.data.event_mask[EVENT_BITS-1:0];
                    end
                S_DECODE:
                begin
                    stat_reg   <= STAT_OK;
                    woken_reg  <= '0;
                    deliv_reg  <= '0;
                    swok_reg   <= 1'b0;
                    i_reg      <= '0;
                    j_reg      <= '0;
                    ni_reg     <= '0;
                    do_ins_reg <= 1'b0;
                    ins_reg    <= tgt_reg;
                    case (act_reg)
                        ACT_RESUME:
                            if (tgt_bad_reg || tstat_reg[tgt_reg] != TSTAT_SUSPENDED)
                                stat_reg <= STAT_STATE;
                            else
                            begin
                                tprio_reg[tgt_reg] <= prio_reg;
                                tstat_reg[tgt_reg] <= TSTAT_READY;
                            end
                        ACT_SUSPEND:
                            if (tgt_bad_reg || tstat_reg[tgt_reg] != TSTAT_READY)
                                stat_reg <= STAT_STATE;
                            else
                                tstat_reg[tgt_reg] <= TSTAT_SUSPENDED;
                        ACT_SETPRIO:
                            if (tgt_bad_reg)
                                stat_reg <= STAT_STATE;
                            else if (tgt_reg == cur_reg)
                                tprio_reg[tgt_reg] <= prio_reg;
                            else if (tstat_reg[tgt_reg] != TSTAT_READY)
                                stat_reg <= STAT_STATE;
                            else
                                do_ins_reg <= 1'b1;
                        ACT_WAIT:
                            if (mask_reg == '0)
                                stat_reg <= STAT_EMPTY;
                            else if (tstat_reg[cur_reg] != TSTAT_READY ||
                                     wcnt_reg >= CW'(NUM_TASKS))
                                stat_reg <= STAT_STATE;
                            else
                            begin
                                tev_reg[cur_reg]   <= mask_reg;
                                tstat_reg[cur_reg] <= TSTAT_BLOCKED;
                                i_reg              <= wcnt_reg;
                            end
                        ACT_NOTIFY:
                            if (mask_reg == '0) stat_reg <= STAT_EMPTY;
                        ACT_SWITCH:
                        begin
                            ins_reg <= cur_reg;
                            i_reg   <= CW'(1);
                            if (tstat_reg[cur_reg] == TSTAT_READY &&
                                rcnt_reg < CW'(NUM_TASKS))
                                i_reg <= '0;
                            else if (rcnt_reg == '0)
                                stat_reg <= STAT_EMPTY;
                        end
                        default: ;
                    endcase
                end
                S_RM_SCAN:
                    if (i_reg < rcnt_reg)
                    begin
                        if (ri != tgt_reg)
                        begin
                            rord_reg[j_reg[TW-1:0]] <= ri;
                            j_reg <= j_reg + 1'b1;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        rcnt_reg <= j_reg;
                        i_reg    <= '0;
                        if (do_ins_reg) tprio_reg[tgt_reg] <= prio_reg;
                    end
                S_INS_SCAN:
                    if (i_reg >= rcnt_reg || tprio_reg[ri] > tprio_reg[ins_reg])
                    begin
                        pos_reg <= i_reg;
                        i_reg   <= rcnt_reg;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                S_INS_SHIFT:
                    if (i_reg > pos_reg)
                    begin
                        rord_reg[i_reg[TW-1:0]] <= rord_reg[i_reg[TW-1:0] - 1'b1];
                        i_reg <= i_reg - 1'b1;
                    end
                    else
                    begin
                        rord_reg[pos_reg[TW-1:0]] <= ins_reg;
                        rcnt_reg <= rcnt_reg + 1'b1;
                        i_reg    <= CW'(1);
                    end
                S_WAIT_SHIFT:
                    if (i_reg != '0)
                    begin
                        word_reg[i_reg[TW-1:0]] <= word_reg[i_reg[TW-1:0] - 1'b1];
                        i_reg <= i_reg - 1'b1;
                    end
                    else
                    begin
                        word_reg[0] <= cur_reg;
                        wcnt_reg    <= wcnt_reg + 1'b1;
                    end
                S_NOT_SCAN:
                    if (ni_reg < wcnt_reg)
                    begin
                        if ((tev_reg[wi] & mask_reg) != '0)
                        begin
                            tev_reg[wi]   <= tev_reg[wi] & mask_reg;
                            tstat_reg[wi] <= TSTAT_READY;
                            woken_reg     <= woken_reg + 1'b1;
                            if (wi != cur_reg && rcnt_reg < CW'(NUM_TASKS))
                            begin
                                // park the scan and queue the woken task
                                ins_reg <= wi;
                                i_reg   <= '0;
                            end
                        end
                        else
                        begin
                            word_reg[j_reg[TW-1:0]] <= wi;
                            j_reg <= j_reg + 1'b1;
                        end
                        ni_reg <= ni_reg + 1'b1;
                    end
                    else
                        wcnt_reg <= j_reg;
                S_POP_SHIFT:
                begin
                    if (i_reg == CW'(1) && !swok_reg)
                    begin
                        cur_reg   <= rord_reg[0];
                        deliv_reg <= tev_reg[rord_reg[0]];
                        tev_reg[rord_reg[0]] <= '0;
                        swok_reg  <= 1'b1;
                    end
                    if (i_reg < rcnt_reg)
                    begin
                        rord_reg[i_reg[TW-1:0] - 1'b1] <= ri;
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                        rcnt_reg <= rcnt_reg - 1'b1;
                end
                S_RESULT:
                    resched_reg <= resched;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rsp.data = '0;
        rsp.data.running_task     = INDEX_W'(cur_reg);
        rsp.data.reschedule       = resched_reg;
        rsp.data.woken_count      = woken_reg;
        rsp.data.delivered_events = EVENTF_W'(deliv_reg);
        rsp.data.status           = stat_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("result and request both open");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rcnt_reg <= CW'(NUM_TASKS)) && (wcnt_reg <= CW'(NUM_TASKS)))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg == S_DECODE)
        else $error("accepted item not decoded");
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for priority_task_scheduler: random and directed requests
// against a scoreboard that tracks task state and queues. Needs pts_pkg, pts_if.
module testbench
    import pts_pkg::*;
();

    localparam int TASKS       = 16;
    localparam int RANDOM_REQS = 1250;
    localparam int CYCLE_LIMIT = 1000000;

    class sched_scoreboard;
        logic [1:0]          task_state [TASKS];
        logic [PRIOF_W-1:0]  task_prio [TASKS];
        logic [EVENTF_W-1:0] task_evts [TASKS];
        int                  ready_q[$];
        int                  wait_q[$];
        int                  running;
        sched_rsp_t          pending_results[$];
        int                  errors;

        function new();
            for (int i = 0; i < TASKS; i++)
            begin
                task_state[i] = TSTAT_SUSPENDED;
                task_prio[i]  = '0;
                task_evts[i]  = '0;
            end
            task_state[0] = TSTAT_READY;
            running = 0;
            errors = 0;
        endfunction

        function void enqueue_ready(int t);
            int pos;
            pos = 0;
            while (pos < ready_q.size() && task_prio[ready_q[pos]] <= task_prio[t])
                pos++;
            ready_q.insert(pos, t);
        endfunction

        function void dequeue_ready(int t);
            for (int i = ready_q.size() - 1; i >= 0; i--)
                if (ready_q[i] == t)
                    ready_q.delete(i);
        endfunction

        function void wake(int t);
            task_state[t] = TSTAT_READY;
            if (t != running)
                enqueue_ready(t);
        endfunction

        function void note_request(sched_req_t r);
            sched_rsp_t e;
            int t;
            int woken;
            int head;
            logic [1:0] st;
            logic [EVENTF_W-1:0] given;
            int keep[$];
            t = r.use_current ? running : int'(r.task_index);
            st = STAT_OK;
            woken = 0;
            given = '0;
            case (r.action)
                ACT_RESUME:
                    if (task_state[t] != TSTAT_SUSPENDED)
                        st = STAT_STATE;
                    else
                    begin
                        task_prio[t] = r.priority_req;
                        wake(t);
                    end
                ACT_SUSPEND:
                    if (task_state[t] != TSTAT_READY)
                        st = STAT_STATE;
                    else
                    begin
                        if (t != running)
                            dequeue_ready(t);
                        task_state[t] = TSTAT_SUSPENDED;
                    end
                ACT_SETPRIO:
                    if (t == running)
                        task_prio[t] = r.priority_req;
                    else if (task_state[t] != TSTAT_READY)
                        st = STAT_STATE;
                    else
                    begin
                        dequeue_ready(t);
                        task_prio[t] = r.priority_req;
                        enqueue_ready(t);
                    end
                ACT_WAIT:
                    if (r.event_mask == '0)
                        st = STAT_EMPTY;
                    else if (task_state[running] != TSTAT_READY || wait_q.size() >= TASKS)
                        st = STAT_STATE;
                    else
                    begin
                        task_evts[running] = r.event_mask;
                        task_state[running] = TSTAT_BLOCKED;
                        wait_q.push_front(running);
                    end
                ACT_NOTIFY:
                    if (r.event_mask == '0)
                        st = STAT_EMPTY;
                    else
                    begin
                        foreach (wait_q[i])
                        begin
                            if ((task_evts[wait_q[i]] & r.event_mask) != '0)
                            begin
                                task_evts[wait_q[i]] &= r.event_mask;
                                wake(wait_q[i]);
                                woken++;
                            end
                            else
                                keep.push_back(wait_q[i]);
                        end
                        wait_q = keep;
                    end
                ACT_SWITCH:
                begin
                    if (task_state[running] == TSTAT_READY)
                        enqueue_ready(running);
                    if (ready_q.size() == 0)
                        st = STAT_EMPTY;
                    else
                    begin
                        head = ready_q.pop_front();
                        running = head;
                        given = task_evts[head];
                        task_evts[head] = '0;
                    end
                end
                default: ;
            endcase
            e.running_task = INDEX_W'(running);
            e.reschedule = task_state[running] != TSTAT_READY ||
                (ready_q.size() > 0 && task_prio[ready_q[0]] < task_prio[running]);
            e.woken_count = WOKEN_W'(woken);
            e.delivered_events = given;
            e.status = st;
            pending_results.push_back(e);
        endfunction

        function void check_result(sched_rsp_t a);
            sched_rsp_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (a.running_task !== e.running_task)
            begin
                $display("%0t: running_task exp %0d got %0d", $time, e.running_task,
                    a.running_task);
                errors++;
            end
            if (a.reschedule !== e.reschedule)
            begin
                $display("%0t: reschedule exp %0d got %0d", $time, e.reschedule, a.reschedule);
                errors++;
            end
            if (a.woken_count !== e.woken_count)
            begin
                $display("%0t: woken_count exp %0d got %0d", $time, e.woken_count,
                    a.woken_count);
                errors++;
            end
            if (a.delivered_events !== e.delivered_events)
            begin
                $display("%0t: delivered_events exp %h got %h", $time, e.delivered_events,
                    a.delivered_events);
                errors++;
            end
            if (a.status !== e.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    bit   calm;

    pts_if #(.payload_t(sched_req_t)) req_ch ();
    pts_if #(.payload_t(sched_rsp_t)) rsp_ch ();

    sched_scoreboard sb;

    priority_task_scheduler DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [EVENTF_W-1:0] pick_mask();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return '0;
        if (r < 60)
            return (32'd1 << $urandom_range(3)) | (($urandom_range(1)) << $urandom_range(3));
        if (r < 85)
            return EVENTF_W'($urandom_range(255));
        return $urandom;
    endfunction

    task automatic send_request(logic [ACTION_W-1:0] act, int idx, bit cur,
                                logic [PRIOF_W-1:0] prio, logic [EVENTF_W-1:0] mask);
        int gap;
        sched_req_t r;
        gap = idle_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        r.action = act;
        r.task_index = INDEX_W'(idx);
        r.use_current = cur;
        r.priority_req = prio;
        r.event_mask = mask;
        req_ch.data <= r;
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random();
        int r;
        logic [ACTION_W-1:0] act;
        r = $urandom_range(99);
        if (r < 25)
            act = ACT_RESUME;
        else if (r < 35)
            act = ACT_SUSPEND;
        else if (r < 47)
            act = ACT_SETPRIO;
        else if (r < 65)
            act = ACT_WAIT;
        else if (r < 82)
            act = ACT_NOTIFY;
        else
            act = ACT_SWITCH;
        send_request(act, $urandom_range(TASKS - 1), $urandom_range(3) == 0,
            PRIOF_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(3)),
            pick_mask());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.data);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.data);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_len();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(8, 1)) @(negedge clk);
        end
    end

    initial
    begin
        sb = new();
        cycles = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(ACT_SWITCH, 0, 0, 0, 0);
        send_request(ACT_WAIT, 0, 0, 0, 32'h1);
        send_request(ACT_SWITCH, 0, 0, 0, 0);
        send_request(ACT_NOTIFY, 0, 0, 0, 0);
        send_request(ACT_WAIT, 0, 0, 0, 0);
        send_request(ACT_NOTIFY, 0, 0, 0, 32'h3);
        send_request(ACT_RESUME, 1, 0, 8'hFF, 0);
        send_request(ACT_RESUME, 2, 0, 8'h00, 0);
        send_request(ACT_RESUME, 2, 0, 8'h10, 0);
        send_request(ACT_RESUME, 0, 1, 8'h00, 0);
        send_request(ACT_SWITCH, 0, 0, 0, 0);
        send_request(ACT_WAIT, 0, 0, 0, 32'hFFFF_FFFF);
        send_request(ACT_NOTIFY, 0, 0, 0, 32'h8000_0000);
        send_request(ACT_SETPRIO, 0, 1, 8'h80, 0);
        send_request(ACT_SETPRIO, 1, 0, 8'h00, 0);
        send_request(ACT_SUSPEND, 1, 0, 0, 0);
        send_request(ACT_SUSPEND, 0, 1, 0, 0);
        send_request(ACT_SUSPEND, 5, 0, 0, 0);
        send_request(ACT_SETPRIO, 7, 0, 8'h01, 0);
        send_request(ACT_SWITCH, 0, 0, 0, 0);
        send_request(ACT_RESUME, 15, 0, 8'hFF, 32'hFFFF_FFFF);
        send_request(ACT_SWITCH, 0, 1, 8'hFF, 0);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            calm = (n % 300) < 40;
            send_random();
        end
        req_ch.valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
